// File: rtl/kll_pkg.sv
// ----------------------------------------------------------------------------
// KLL sketch package
// Shared constants, codes and the sequencer state type of the quantile sketch.
// ----------------------------------------------------------------------------
package kll_pkg;

    // Sketch geometry.
    localparam int MAX_LEVELS  = 16;
    localparam int LEVEL_DEPTH = 256;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int IDX_W       = $clog2(LEVEL_DEPTH);
    localparam int FILL_W      = IDX_W + 1;
    localparam int ADDR_W      = LVL_W + IDX_W;
    localparam int STORE_DEPTH = MAX_LEVELS * LEVEL_DEPTH;

    // Word widths.
    localparam int DATA_W  = 32;
    localparam int COIN_W  = 16;
    localparam int RANK_W  = 24;
    localparam int ACC_W   = RANK_W + 4;
    localparam int K_W     = 9;
    localparam int C_W     = 16;
    localparam int V_W     = K_W + C_W;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Minimum capacity of any level.
    localparam int MIN_CAP = 2;

    // Register reset values.
    localparam logic [K_W-1:0] K_RESET = 9'd128;
    localparam logic [C_W-1:0] C_RESET = 16'd43691;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_RATIO   = 1'd1;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP_START,
        ST_CAP_WAIT,
        ST_C_INIT,
        ST_C_PREAD,
        ST_C_PGET,
        ST_C_SCAN,
        ST_C_EMIT,
        ST_C_DONE,
        ST_Q_START,
        ST_Q_SCAN
    } state_t;

endpackage

// File: rtl/kll_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/kll_cap.sv
// ----------------------------------------------------------------------------
// KLL level capacity unit
// Scales K by C once per cycle with one shared multiplier, then rounds up and
// clamps the result to the legal capacity range.
// ----------------------------------------------------------------------------
module kll_cap (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kll_pkg::LVL_W-1:0]  depth,
    input  logic [kll_pkg::K_W-1:0]    base_cap,
    input  logic [kll_pkg::C_W-1:0]    ratio,
    output logic                       done,
    output logic [kll_pkg::FILL_W-1:0] cap
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [kll_pkg::LVL_W-1:0]         cnt_reg, cnt_next;
    logic [kll_pkg::V_W-1:0]           v_reg, v_next;
    logic [kll_pkg::FILL_W-1:0]        cap_reg, cap_next;
    logic [kll_pkg::V_W+kll_pkg::C_W-1:0] prod;
    logic [kll_pkg::V_W:0]             v_round;
    logic [kll_pkg::K_W:0]             c_raw;

    // Shared multiplier and rounding.
    assign prod    = v_reg * ratio;
    assign v_round = {1'b0, v_reg} + (kll_pkg::V_W+1)'(16'hFFFF);
    assign c_raw   = v_round[kll_pkg::V_W:kll_pkg::C_W];

    // Step control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        cap_next  = cap_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = depth;
            v_next    = {base_cap, {kll_pkg::C_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (c_raw < (kll_pkg::K_W+1)'(kll_pkg::MIN_CAP))
                begin
                    cap_next = kll_pkg::FILL_W'(kll_pkg::MIN_CAP);
                end
                else if (c_raw > (kll_pkg::K_W+1)'(kll_pkg::LEVEL_DEPTH))
                begin
                    cap_next = kll_pkg::FILL_W'(kll_pkg::LEVEL_DEPTH);
                end
                else
                begin
                    cap_next = c_raw[kll_pkg::FILL_W-1:0];
                end
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                v_next   = prod[kll_pkg::V_W+kll_pkg::C_W-1:kll_pkg::C_W];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        cap_reg <= cap_next;
    end

    assign done = done_reg;
    assign cap  = cap_reg;

endmodule

// File: rtl/kll_quantile_sketch_top.sv
// ----------------------------------------------------------------------------
// KLL quantile sketch
// Streaming quantile sketch with compaction by rank selection and a rank query.
// ----------------------------------------------------------------------------
//   Channel   Signals                                  Direction
//   command   start, busy, operation, value, coin_bits  in (busy out)
//   result    done, rank_estimate, overflowed          out, one-cycle strobe
//   config    cfg_we, cfg_index, cfg_data              in, no wait
//
// A query keeps busy high while it scans each level up to the top level; the
// single store read port sets the pace. The result word is strobed in the
// cycle in which busy falls.
// An insert visits each level in turn and runs the capacity multiplier for it,
// then compacts each level that has reached its capacity; each word's rank is
// found by a scan of its level, and a closing state ends the insert.
// The receiver cannot stall: results are never held back.
// Reset clears fills, top level and overflow flag; the store needs no clear.
// ----------------------------------------------------------------------------
module kll_quantile_sketch_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic signed [kll_pkg::DATA_W-1:0] value,
    input  logic [kll_pkg::COIN_W-1:0]     coin_bits,
    output logic                           done,
    output logic [kll_pkg::RANK_W-1:0]     rank_estimate,
    output logic                           overflowed,
    input  logic                           cfg_we,
    input  logic [kll_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kll_pkg::CFG_W-1:0]      cfg_data
);

    kll_pkg::state_t                state_reg, state_next;
    logic [kll_pkg::LVL_W:0]        lvl_reg, lvl_next;
    logic [kll_pkg::LVL_W-1:0]      top_reg, top_next;
    logic                           ovf_reg, ovf_next;
    logic [kll_pkg::DATA_W-1:0]     value_reg, value_next;
    logic [kll_pkg::COIN_W-1:0]     coin_reg, coin_next;
    logic [kll_pkg::FILL_W-1:0]     n_reg, n_next;
    logic                           coin_sel_reg, coin_sel_next;
    logic [kll_pkg::IDX_W-1:0]      i_reg, i_next;
    logic [kll_pkg::DATA_W-1:0]     pivot_reg, pivot_next;
    logic [kll_pkg::FILL_W-1:0]     j_reg, j_next;
    logic                           pend_reg, pend_next;
    logic [kll_pkg::IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [kll_pkg::FILL_W-1:0]     cnt_reg, cnt_next;
    logic [kll_pkg::FILL_W-1:0]     dbase_reg, dbase_next;
    logic [kll_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic                           done_reg, done_next;
    logic [kll_pkg::RANK_W-1:0]     rank_reg, rank_next;
    logic [kll_pkg::K_W-1:0]        k_reg;
    logic [kll_pkg::C_W-1:0]        c_reg;

    logic [kll_pkg::FILL_W-1:0]     fill_reg [kll_pkg::MAX_LEVELS];
    logic [kll_pkg::LVL_W-1:0]      fill_ridx;
    logic [kll_pkg::FILL_W-1:0]     fill_q;
    logic                           fill_we;
    logic [kll_pkg::LVL_W-1:0]      fill_widx;
    logic [kll_pkg::FILL_W-1:0]     fill_wdata;

    logic                           ram_we;
    logic [kll_pkg::ADDR_W-1:0]     ram_waddr;
    logic [kll_pkg::DATA_W-1:0]     ram_wdata;
    logic [kll_pkg::ADDR_W-1:0]     ram_raddr;
    logic [kll_pkg::DATA_W-1:0]     ram_rdata;

    logic                           cap_start;
    logic [kll_pkg::LVL_W-1:0]      cap_depth;
    logic                           cap_done;
    logic [kll_pkg::FILL_W-1:0]     cap_val;

    logic [kll_pkg::LVL_W-1:0]      lvl_lo;
    logic [kll_pkg::LVL_W-1:0]      lvl_up;
    logic [kll_pkg::DATA_W-1:0]     cmp_op;
    logic                           cmp_lt;
    logic                           cmp_eq;
    logic                           scan_more;
    logic [kll_pkg::FILL_W-1:0]     dest_base;
    logic [kll_pkg::FILL_W:0]       surv_cnt;
    logic [kll_pkg::FILL_W:0]       dest_end;
    logic [kll_pkg::FILL_W:0]       emit_pos;

    assign lvl_lo = lvl_reg[kll_pkg::LVL_W-1:0];
    assign lvl_up = lvl_lo + 1'b1;

    // Level store.
    kll_ram #(
        .WIDTH (kll_pkg::DATA_W),
        .DEPTH (kll_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capacity unit.
    kll_cap u_cap (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cap_start),
        .depth    (cap_depth),
        .base_cap (k_reg),
        .ratio    (c_reg),
        .done     (cap_done),
        .cap      (cap_val)
    );

    // Shared signed compare against the pivot or the query key.
    assign cmp_op    = (state_reg == kll_pkg::ST_Q_SCAN) ? value_reg : pivot_reg;
    assign cmp_lt    = $signed(ram_rdata) < $signed(cmp_op);
    assign cmp_eq    = ram_rdata == cmp_op;
    assign scan_more = j_reg < n_reg;
    assign fill_q    = fill_reg[fill_ridx];
    assign cap_depth = top_reg - lvl_lo;

    // Survivors land in sorted order after the words already in the level above:
    // the survivor of rank r goes to slot base + r / 2.
    assign dest_base = (lvl_lo == top_reg) ? '0 : fill_q;
    assign surv_cnt  = ({1'b0, n_reg} + 1'b1
                        - {{kll_pkg::FILL_W{1'b0}}, coin_sel_reg}) >> 1;
    assign dest_end  = {1'b0, dest_base} + surv_cnt;
    assign emit_pos  = {1'b0, dbase_reg} + {2'b00, cnt_reg[kll_pkg::FILL_W-1:1]};

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        top_next      = top_reg;
        ovf_next      = ovf_reg;
        value_next    = value_reg;
        coin_next     = coin_reg;
        n_next        = n_reg;
        coin_sel_next = coin_sel_reg;
        i_next        = i_reg;
        pivot_next    = pivot_reg;
        j_next        = j_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cnt_next      = cnt_reg;
        dbase_next    = dbase_reg;
        acc_next      = acc_reg;
        done_next     = 1'b0;
        rank_next     = rank_reg;
        fill_ridx     = lvl_lo;
        fill_we       = 1'b0;
        fill_widx     = lvl_lo;
        fill_wdata    = '0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = pivot_reg;
        ram_raddr     = {lvl_lo, j_reg[kll_pkg::IDX_W-1:0]};
        cap_start     = 1'b0;

        unique case (state_reg)
            kll_pkg::ST_IDLE:
            begin
                fill_ridx = '0;
                if (start)
                begin
                    value_next = value;
                    coin_next  = coin_bits;
                    lvl_next   = '0;
                    acc_next   = '0;
                    if (operation == kll_pkg::OP_INSERT)
                    begin
                        if (fill_q < kll_pkg::FILL_W'(kll_pkg::LEVEL_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = {kll_pkg::LVL_W'(0), fill_q[kll_pkg::IDX_W-1:0]};
                            ram_wdata  = value;
                            fill_we    = 1'b1;
                            fill_widx  = '0;
                            fill_wdata = fill_q + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        state_next = kll_pkg::ST_CAP_START;
                    end
                    else
                    begin
                        state_next = kll_pkg::ST_Q_START;
                    end
                end
            end

            // Visit the next level, or finish the insert.
            kll_pkg::ST_CAP_START:
            begin
                if (lvl_reg > {1'b0, top_reg})
                begin
                    state_next = kll_pkg::ST_IDLE;
                end
                else
                begin
                    cap_start  = 1'b1;
                    state_next = kll_pkg::ST_CAP_WAIT;
                end
            end

            kll_pkg::ST_CAP_WAIT:
            begin
                if (cap_done)
                begin
                    if (fill_q >= cap_val)
                    begin
                        n_next        = fill_q;
                        coin_sel_next = coin_reg[lvl_lo];
                        state_next    = kll_pkg::ST_C_INIT;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = kll_pkg::ST_CAP_START;
                    end
                end
            end

            // Open a new top level if this is the top, set the final fill of the level
            // above, or drop survivors at the last level.
            kll_pkg::ST_C_INIT:
            begin
                i_next = '0;
                if (lvl_lo == kll_pkg::LVL_W'(kll_pkg::MAX_LEVELS - 1))
                begin
                    if ({{(kll_pkg::FILL_W-1){1'b0}}, coin_sel_reg} < n_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = kll_pkg::ST_C_DONE;
                end
                else
                begin
                    fill_ridx  = lvl_up;
                    dbase_next = dest_base;
                    if (lvl_lo == top_reg)
                    begin
                        top_next = lvl_up;
                    end
                    fill_we   = 1'b1;
                    fill_widx = lvl_up;
                    if (dest_end > (kll_pkg::FILL_W+1)'(kll_pkg::LEVEL_DEPTH))
                    begin
                        fill_wdata = kll_pkg::FILL_W'(kll_pkg::LEVEL_DEPTH);
                    end
                    else
                    begin
                        fill_wdata = dest_end[kll_pkg::FILL_W-1:0];
                    end
                    state_next = kll_pkg::ST_C_PREAD;
                end
            end

            kll_pkg::ST_C_PREAD:
            begin
                ram_raddr  = {lvl_lo, i_reg};
                state_next = kll_pkg::ST_C_PGET;
            end

            kll_pkg::ST_C_PGET:
            begin
                pivot_next = ram_rdata;
                j_next     = '0;
                cnt_next   = '0;
                state_next = kll_pkg::ST_C_SCAN;
            end

            // Rank of the pivot within its level, ties broken by position.
            kll_pkg::ST_C_SCAN:
            begin
                if (scan_more)
                begin
                    j_next        = j_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = j_reg[kll_pkg::IDX_W-1:0];
                end
                if (pend_reg && (cmp_lt || (cmp_eq && (pend_idx_reg < i_reg))))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!scan_more && !pend_reg)
                begin
                    state_next = kll_pkg::ST_C_EMIT;
                end
            end

            // Move a survivor up one level, into its sorted slot.
            kll_pkg::ST_C_EMIT:
            begin
                if (cnt_reg[0] == coin_sel_reg)
                begin
                    if (emit_pos < (kll_pkg::FILL_W+1)'(kll_pkg::LEVEL_DEPTH))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = {lvl_up, emit_pos[kll_pkg::IDX_W-1:0]};
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                i_next = i_reg + 1'b1;
                if (({1'b0, i_reg} + 1'b1) < n_reg)
                begin
                    state_next = kll_pkg::ST_C_PREAD;
                end
                else
                begin
                    state_next = kll_pkg::ST_C_DONE;
                end
            end

            kll_pkg::ST_C_DONE:
            begin
                fill_we    = 1'b1;
                fill_widx  = lvl_lo;
                fill_wdata = '0;
                lvl_next   = lvl_reg + 1'b1;
                state_next = kll_pkg::ST_CAP_START;
            end

            // Query: visit each level, or deliver the word.
            kll_pkg::ST_Q_START:
            begin
                if (lvl_reg > {1'b0, top_reg})
                begin
                    done_next = 1'b1;
                    if (acc_reg > kll_pkg::ACC_W'({kll_pkg::RANK_W{1'b1}}))
                    begin
                        rank_next = {kll_pkg::RANK_W{1'b1}};
                    end
                    else
                    begin
                        rank_next = acc_reg[kll_pkg::RANK_W-1:0];
                    end
                    state_next = kll_pkg::ST_IDLE;
                end
                else
                begin
                    n_next     = fill_q;
                    j_next     = '0;
                    state_next = kll_pkg::ST_Q_SCAN;
                end
            end

            kll_pkg::ST_Q_SCAN:
            begin
                if (scan_more)
                begin
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && cmp_lt)
                begin
                    acc_next = acc_reg + (kll_pkg::ACC_W'(1) << lvl_lo);
                end
                if (!scan_more && !pend_reg)
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = kll_pkg::ST_Q_START;
                end
            end

            default:
            begin
                state_next = kll_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kll_pkg::ST_IDLE;
            top_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= kll_pkg::K_RESET;
            c_reg     <= kll_pkg::C_RESET;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kll_pkg::CFG_LEVEL_CAPACITY: k_reg <= cfg_data[kll_pkg::K_W-1:0];
                    kll_pkg::CFG_SHRINK_RATIO:   c_reg <= cfg_data[kll_pkg::C_W-1:0];
                    default:                     ;
                endcase
            end
        end
    end

    // Level fill counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < kll_pkg::MAX_LEVELS; l++)
            begin
                fill_reg[l] <= '0;
            end
        end
        else if (fill_we)
        begin
            fill_reg[fill_widx] <= fill_wdata;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        value_reg    <= value_next;
        coin_reg     <= coin_next;
        n_reg        <= n_next;
        coin_sel_reg <= coin_sel_next;
        i_reg        <= i_next;
        pivot_reg    <= pivot_next;
        j_reg        <= j_next;
        pend_idx_reg <= pend_idx_next;
        cnt_reg      <= cnt_next;
        dbase_reg    <= dbase_next;
        acc_reg      <= acc_next;
        rank_reg     <= rank_next;
    end

    assign busy          = (state_reg != kll_pkg::ST_IDLE);
    assign done          = done_reg;
    assign rank_estimate = rank_reg;
    assign overflowed    = ovf_reg;

    // The overflow flag is sticky.
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ovf_reg) |-> ovf_reg)
        else $error("overflow flag cleared");

    // The top level never shrinks.
    a_top_grows: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg >= $past(top_reg))
        else $error("top level decreased");

    // A result word only follows the end of a query.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == kll_pkg::ST_Q_START))
        else $error("result word outside a query");

endmodule

// File: test/tb_kll_quantile_sketch_top.sv
// ----------------------------------------------------------------------------
// Quantile sketch testbench
// Drives insert and rank-query words into the sketch and keeps its own copy of
// the sketch levels to work out every rank and overflow flag. Each result is
// checked against the oldest predicted word. The stimulus covers a directed
// set of corner cases and random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_kll_quantile_sketch_top;

    timeunit 1ns;
    timeprecision 1ps;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic                             operation;
    logic signed [kll_pkg::DATA_W-1:0] value;
    logic [kll_pkg::COIN_W-1:0]       coin_bits;
    logic                             done;
    logic [kll_pkg::RANK_W-1:0]       rank_estimate;
    logic                             overflowed;
    logic                             cfg_we;
    logic [kll_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [kll_pkg::CFG_W-1:0]        cfg_data;

    // Shadow copy of the sketch.
    logic signed [kll_pkg::DATA_W-1:0] level_words [kll_pkg::MAX_LEVELS][kll_pkg::LEVEL_DEPTH];
    int unsigned                      level_count [kll_pkg::MAX_LEVELS];
    int unsigned                      top_lvl;
    bit                               ovf_seen;
    int unsigned                      cap_k;
    int unsigned                      ratio_c;

    // Predicted query words, oldest first.
    logic [kll_pkg::RANK_W-1:0]       rank_queue [$];
    bit                               ovf_queue [$];
    int                               errors;

    kll_quantile_sketch_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .value         (value),
        .coin_bits     (coin_bits),
        .done          (done),
        .rank_estimate (rank_estimate),
        .overflowed    (overflowed),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Capacity of a level lying depth levels below the top.
    function automatic int unsigned level_cap(int unsigned depth);
        longint unsigned v;
        longint unsigned c;
        v = longint'(cap_k) << 16;
        for (int i = 0; i < depth; i++)
            v = (v * ratio_c) >> 16;
        c = (v + 64'hFFFF) >> 16;
        if (c < kll_pkg::MIN_CAP)
            c = kll_pkg::MIN_CAP;
        if (c > kll_pkg::LEVEL_DEPTH)
            c = kll_pkg::LEVEL_DEPTH;
        return int'(c);
    endfunction

    // Sort a level, then promote every second word from the coin index.
    function automatic void compact_level(int unsigned l, int unsigned coin);
        int unsigned n;
        int unsigned j;
        logic signed [kll_pkg::DATA_W-1:0] t;
        n = level_count[l];
        for (int unsigned i = 1; i < n; i++)
        begin
            t = level_words[l][i];
            j = i;
            while (j > 0 && level_words[l][j-1] > t)
            begin
                level_words[l][j] = level_words[l][j-1];
                j--;
            end
            level_words[l][j] = t;
        end
        if (l + 1 < kll_pkg::MAX_LEVELS)
        begin
            if (l == top_lvl)
            begin
                top_lvl = l + 1;
                level_count[l+1] = 0;
            end
            for (int unsigned i = coin; i < n; i += 2)
            begin
                if (level_count[l+1] < kll_pkg::LEVEL_DEPTH)
                begin
                    level_words[l+1][level_count[l+1]] = level_words[l][i];
                    level_count[l+1]++;
                end
                else
                    ovf_seen = 1'b1;
            end
        end
        else if (coin < n)
            ovf_seen = 1'b1;
        level_count[l] = 0;
    endfunction

    function automatic void sketch_insert(logic signed [kll_pkg::DATA_W-1:0] x,
                                          logic [kll_pkg::COIN_W-1:0] coins);
        if (level_count[0] < kll_pkg::LEVEL_DEPTH)
        begin
            level_words[0][level_count[0]] = x;
            level_count[0]++;
        end
        else
            ovf_seen = 1'b1;
        for (int unsigned l = 0; l <= top_lvl && l < kll_pkg::MAX_LEVELS; l++)
            if (level_count[l] >= level_cap(top_lvl - l))
                compact_level(l, coins[l % kll_pkg::COIN_W]);
    endfunction

    function automatic logic [kll_pkg::RANK_W-1:0] sketch_rank(
        logic signed [kll_pkg::DATA_W-1:0] x);
        longint unsigned total;
        longint unsigned cnt;
        total = 0;
        for (int unsigned l = 0; l <= top_lvl && l < kll_pkg::MAX_LEVELS; l++)
        begin
            cnt = 0;
            for (int unsigned i = 0; i < level_count[l]; i++)
                if (level_words[l][i] < x)
                    cnt++;
            total += cnt << l;
        end
        if (total > 64'hFFFFFF)
            total = 64'hFFFFFF;
        return total[kll_pkg::RANK_W-1:0];
    endfunction

    // Send one command word and predict its effect once it is taken.
    task automatic send_word(logic op, logic signed [kll_pkg::DATA_W-1:0] x,
                             logic [kll_pkg::COIN_W-1:0] coins);
        @(negedge clk);
        start     = 1'b1;
        operation = op;
        value     = x;
        coin_bits = coins;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (op == kll_pkg::OP_INSERT)
            sketch_insert(x, coins);
        else
        begin
            rank_queue = {rank_queue, sketch_rank(x)};
            ovf_queue  = {ovf_queue, ovf_seen};
        end
    endtask

    task automatic idle_cycles(int n);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Wait until every query word has come back and the block is idle.
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (rank_queue.size() > 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [kll_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data[kll_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == kll_pkg::CFG_LEVEL_CAPACITY)
            cap_k = data & 32'h1FF;
        else
            ratio_c = data & 32'hFFFF;
    endtask

    // Check each result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rank_queue.size() == 0)
            begin
                $display("%0t: expected no result, actual rank %0d overflowed %0b",
                         $time, rank_estimate, overflowed);
                errors++;
            end
            else
            begin
                if (rank_estimate !== rank_queue[0])
                begin
                    $display("%0t: rank_estimate expected %0d actual %0d",
                             $time, rank_queue[0], rank_estimate);
                    errors++;
                end
                if (overflowed !== ovf_queue[0])
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, ovf_queue[0], overflowed);
                    errors++;
                end
                void'(rank_queue.pop_front());
                void'(ovf_queue.pop_front());
            end
        end
    end

    // Field extremes, both operations and extreme register values.
    task automatic test_directed;
        write_reg(kll_pkg::CFG_LEVEL_CAPACITY, 2);
        write_reg(kll_pkg::CFG_SHRINK_RATIO, 32769);
        send_word(kll_pkg::OP_INSERT, 32'sh80000000, 16'h0000);
        send_word(kll_pkg::OP_INSERT, 32'sh7FFFFFFF, 16'hFFFF);
        send_word(kll_pkg::OP_QUERY, 32'sh80000000, 16'h0000);
        send_word(kll_pkg::OP_QUERY, 32'sh7FFFFFFF, 16'hFFFF);
        send_word(kll_pkg::OP_INSERT, 0, 16'hAAAA);
        send_word(kll_pkg::OP_INSERT, -1, 16'h5555);
        send_word(kll_pkg::OP_INSERT, 1, 16'hFFFF);
        send_word(kll_pkg::OP_QUERY, 0, 16'h0000);
        send_word(kll_pkg::OP_QUERY, 1, 16'h0000);
        // Capacity values below the minimum fall back to two.
        write_reg(kll_pkg::CFG_LEVEL_CAPACITY, 0);
        send_word(kll_pkg::OP_INSERT, 32'sh12345678, 16'h0000);
        send_word(kll_pkg::OP_INSERT, -32'sh12345678, 16'hFFFF);
        send_word(kll_pkg::OP_QUERY, 0, 16'h0000);
        write_reg(kll_pkg::CFG_LEVEL_CAPACITY, 1);
        write_reg(kll_pkg::CFG_SHRINK_RATIO, 0);
        send_word(kll_pkg::OP_INSERT, 7, 16'h0000);
        send_word(kll_pkg::OP_INSERT, -7, 16'h0001);
        send_word(kll_pkg::OP_QUERY, 8, 16'h0000);
        // Capacity beyond its range is cut to the level depth.
        write_reg(kll_pkg::CFG_LEVEL_CAPACITY, 511);
        write_reg(kll_pkg::CFG_SHRINK_RATIO, 65535);
        send_word(kll_pkg::OP_INSERT, 100, 16'h0000);
        send_word(kll_pkg::OP_QUERY, 101, 16'hFFFF);
        send_word(kll_pkg::OP_QUERY, -2, 16'h0000);
    endtask

    // Random traffic in bursts under a series of register settings.
    task automatic test_random;
        int unsigned k_set [8] = '{2, 3, 8, 16, 128, 4, 256, 6};
        int unsigned c_set [8] = '{32769, 65535, 43691, 50000, 43691, 32769, 65535, 60000};
        int burst;
        int sel;
        int n;
        logic signed [kll_pkg::DATA_W-1:0] x;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(kll_pkg::CFG_LEVEL_CAPACITY, k_set[ph]);
            write_reg(kll_pkg::CFG_SHRINK_RATIO, (ph == 3) ? $urandom_range(65535, 32769)
                                                           : c_set[ph]);
            n = 0;
            while (n < 50)
            begin
                burst = $urandom_range(20, 1);
                for (int b = 0; b < burst && n < 50; b++)
                begin
                    sel = $urandom_range(9);
                    if (sel < 5)
                        x = $urandom;
                    else if (sel < 8)
                        x = $signed($urandom_range(64)) - 32;
                    else if (sel == 8)
                        x = 32'sh80000000 + $urandom_range(3);
                    else
                        x = 32'sh7FFFFFFF - $urandom_range(3);
                    send_word(($urandom_range(9) < 3) ? kll_pkg::OP_QUERY
                                                      : kll_pkg::OP_INSERT,
                              x, kll_pkg::COIN_W'($urandom));
                    n++;
                end
                if ($urandom_range(3) != 0)
                    idle_cycles($urandom_range(30));
            end
            // After the fifth setting, hold off until all outstanding queries have returned.
            if (ph == 4)
                drain();
        end
    endtask

    initial
    begin
        errors    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = kll_pkg::OP_INSERT;
        value     = '0;
        coin_bits = '0;
        cfg_we    = 1'b0;
        cfg_index = kll_pkg::CFG_LEVEL_CAPACITY;
        cfg_data  = '0;
        for (int l = 0; l < kll_pkg::MAX_LEVELS; l++)
            level_count[l] = 0;
        top_lvl  = 0;
        ovf_seen = 1'b0;
        cap_k    = 128;
        ratio_c  = 43691;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/kll_pkg.sv
rtl/kll_ram.sv
rtl/kll_cap.sv
rtl/kll_quantile_sketch_top.sv
test/tb_kll_quantile_sketch_top.sv
